// ===== rtl/hysteresis_activity_segmenter_defines.svh =====
// ---------------------------------------------------------------------------
// Hysteresis activity segmenter assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef HYSTERESIS_ACTIVITY_SEGMENTER_DEFINES_SVH
`define HYSTERESIS_ACTIVITY_SEGMENTER_DEFINES_SVH

// same-cycle implication
`define HAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/has_pkg.sv =====
// ---------------------------------------------------------------------------
// Hysteresis activity segmenter package
// Sizes, register indexes and the types shared by the lanes and the merge.
// ---------------------------------------------------------------------------
package has_pkg;

    localparam int CLASS_LANES = 4;
    localparam int FRAME_BITS  = 16;
    localparam int SCORE_BITS  = 16;

    localparam int CLASS_BITS     = (CLASS_LANES > 1) ? $clog2(CLASS_LANES) : 1;
    localparam int CLASS_CNT_BITS = 3;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = SCORE_BITS;

    localparam int S_DATA_BITS  = ((CLASS_LANES * SCORE_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = CLASS_BITS + 2 * FRAME_BITS;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic [SCORE_BITS-1:0] score_t;

    localparam frame_t FRAME_MAX   = '1;
    localparam score_t LEVEL_RESET = score_t'(1) << (SCORE_BITS - 1);
    localparam logic [CLASS_CNT_BITS-1:0] CLASSES_RESET = CLASS_CNT_BITS'(CLASS_LANES);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ONSET   = 2'd0,
        CFG_OFFSET  = 2'd1,
        CFG_CLASSES = 2'd2
    } cfg_reg_e;

    // per-frame context broadcast to all lanes
    typedef struct packed {
        logic   first;
        logic   last;
        frame_t frame;
        score_t onset;
        score_t offset;
    } frame_ctl_t;

    // what one lane reports for the accepted frame
    typedef struct packed {
        logic   emit;
        frame_t start;
    } lane_res_t;

endpackage

// ===== rtl/has_lane.sv =====
// ---------------------------------------------------------------------------
// Hysteresis lane
// Two-level threshold tracker for one class: active flag and start frame.
// ---------------------------------------------------------------------------
module has_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                in_use,
    input  has_pkg::score_t     score,
    input  has_pkg::frame_ctl_t ctl,
    output has_pkg::lane_res_t  res
);

    logic            active_reg;
    logic            active_next;
    has_pkg::frame_t start_reg;
    has_pkg::frame_t start_next;

    always_comb
    begin
        active_next = active_reg;
        start_next  = start_reg;
        res.emit    = 1'b0;
        res.start   = start_reg;
        if (!in_use)
        begin
            active_next = 1'b0;
            start_next  = '0;
        end
        else if (ctl.first)
        begin
            active_next = (score > ctl.onset);
            start_next  = '0;
            res.start   = '0;
            res.emit    = ctl.last && active_next;
        end
        else if (active_reg)
        begin
            if (score < ctl.offset || ctl.last)
            begin
                res.emit    = 1'b1;
                active_next = 1'b0;
            end
        end
        else if (score > ctl.onset)
        begin
            start_next  = ctl.frame;
            active_next = 1'b1;
            res.start   = ctl.frame;
            res.emit    = ctl.last;
        end
        if (ctl.last)
        begin
            active_next = 1'b0;
            start_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            start_reg  <= '0;
        end
        else if (accept)
        begin
            active_reg <= active_next;
            start_reg  <= start_next;
        end
    end

endmodule

// ===== rtl/has_merge.sv =====
// ---------------------------------------------------------------------------
// Segment merge
// Captures the segments closed by one frame and sends them out one per
// request in rising class order.
// ---------------------------------------------------------------------------
module has_merge (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       load,
    input  logic [has_pkg::CLASS_LANES-1:0]            emit,
    input  has_pkg::frame_t [has_pkg::CLASS_LANES-1:0] starts,
    input  has_pkg::frame_t                            end_frame,
    output logic                                       free,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [has_pkg::M_DATA_BITS-1:0]            m_tdata,  // class_index, start_frame, end_frame
    output logic                                       m_tlast   // last_in_run
);

    logic [has_pkg::CLASS_LANES-1:0]            mask_reg;
    logic [has_pkg::CLASS_LANES-1:0]            mask_next;
    has_pkg::frame_t [has_pkg::CLASS_LANES-1:0] starts_reg;
    has_pkg::frame_t                            end_reg;
    logic [has_pkg::CLASS_BITS-1:0]             pick;

    always_comb
    begin
        pick = '0;
        for (int i = has_pkg::CLASS_LANES - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick = has_pkg::CLASS_BITS'(i);
            end
        end
    end

    assign m_tvalid = |mask_reg;
    assign m_tlast  = (mask_reg & (mask_reg - 1'b1)) == '0;
    assign m_tdata  = has_pkg::M_DATA_BITS'({end_reg, starts_reg[pick], pick});
    assign free     = !m_tvalid || (m_tready && m_tlast);

    always_comb
    begin
        mask_next = mask_reg;
        if (m_tvalid && m_tready)
        begin
            mask_next = mask_reg & (mask_reg - 1'b1);
        end
        if (load)
        begin
            mask_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            starts_reg <= starts;
            end_reg    <= end_frame;
        end
    end

endmodule

// ===== rtl/hysteresis_activity_segmenter.sv =====
// ---------------------------------------------------------------------------
// Hysteresis activity segmenter
// Per-class onset/offset thresholding of activity scores into segments.
// ---------------------------------------------------------------------------
// One frame of class scores is taken per request. A frame closing at most one
// segment does not block the next, so while m_tready is high such frames stream
// at one per clock; a frame closing n segments sends them one per cycle while
// m_tready is high, and the next frame is taken in the cycle the last leaves.
// The single result slot of the merge stage sets this rate. Segments come out
// in closing order, rising class within a frame, with tlast on the final one.
// The user writes levels and lane count only while idle; it is not enforced.
module hysteresis_activity_segmenter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [has_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [has_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [has_pkg::S_DATA_BITS-1:0]      s_tdata,  // score_0 .. score_3
    input  logic                                 s_tlast,  // last_frame
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [has_pkg::M_DATA_BITS-1:0]      m_tdata,  // class_index, start_frame, end_frame
    output logic                                 m_tlast   // last_in_run
);

`include "hysteresis_activity_segmenter_defines.svh"

    has_pkg::score_t                          onset_reg;
    has_pkg::score_t                          offset_reg;
    logic [has_pkg::CLASS_CNT_BITS-1:0]       classes_reg;
    has_pkg::frame_t                          frame_reg;
    has_pkg::frame_t                          frame_next;
    logic                                     accept;
    logic [has_pkg::CLASS_LANES-1:0]          in_use;
    logic [has_pkg::CLASS_LANES-1:0]          emit;
    has_pkg::frame_t [has_pkg::CLASS_LANES-1:0] starts;
    has_pkg::lane_res_t [has_pkg::CLASS_LANES-1:0] res;
    has_pkg::frame_ctl_t                      ctl;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            onset_reg   <= has_pkg::LEVEL_RESET;
            offset_reg  <= has_pkg::LEVEL_RESET;
            classes_reg <= has_pkg::CLASSES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                has_pkg::CFG_ONSET:   onset_reg   <= cfg_data[has_pkg::SCORE_BITS-1:0];
                has_pkg::CFG_OFFSET:  offset_reg  <= cfg_data[has_pkg::SCORE_BITS-1:0];
                has_pkg::CFG_CLASSES: classes_reg <= cfg_data[has_pkg::CLASS_CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < has_pkg::CLASS_LANES; i++)
        begin
            in_use[i] = (i == 0) || (has_pkg::CLASS_CNT_BITS'(i) < classes_reg);
        end
    end

    assign ctl.first  = (frame_reg == '0);
    assign ctl.last   = s_tlast;
    assign ctl.frame  = frame_reg;
    assign ctl.onset  = onset_reg;
    assign ctl.offset = offset_reg;

    always_comb
    begin
        if (s_tlast)
        begin
            frame_next = '0;
        end
        else if (frame_reg == has_pkg::FRAME_MAX)
        begin
            frame_next = frame_reg;
        end
        else
        begin
            frame_next = frame_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else if (accept)
        begin
            frame_reg <= frame_next;
        end
    end

    for (genvar c = 0; c < has_pkg::CLASS_LANES; c++)
    begin : g_lane
        has_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .accept (accept),
            .in_use (in_use[c]),
            .score  (s_tdata[c*has_pkg::SCORE_BITS +: has_pkg::SCORE_BITS]),
            .ctl    (ctl),
            .res    (res[c])
        );
        assign emit[c]   = res[c].emit;
        assign starts[c] = res[c].start;
    end

    has_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .emit      (emit),
        .starts    (starts),
        .end_frame (frame_reg),
        .free      (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    `HAS_ASSERT_NOW(a_take_on_final, s_tready && m_tvalid, m_tready && m_tlast, "frame taken with segments still queued")
    `HAS_ASSERT_NEXT(a_clear_on_last, accept && s_tlast, frame_reg == '0, "frame index not cleared after last frame")
    `HAS_ASSERT_NEXT(a_count_up, accept && !s_tlast && (frame_reg != has_pkg::FRAME_MAX), frame_reg == has_pkg::FRAME_BITS'($past(frame_reg) + 1'b1), "frame index did not advance")
    `HAS_ASSERT_NEXT(a_saturate, accept && !s_tlast && (frame_reg == has_pkg::FRAME_MAX), frame_reg == has_pkg::FRAME_MAX, "frame index left saturation")

endmodule
